>>> sv/krtn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the k-ary reduction tree neighbor block
// no dependencies; used by krtn_div, kary_reduction_tree_neighbors and krtn_chk
package krtn_pkg;

  localparam int NODE_W     = 16;     // node number width
  localparam int FAN_W      = 5;      // fan-in register width
  localparam int LEAF_W     = 17;     // leaf count register width
  localparam int PW_W       = 20;     // powers of the fan-in, below leaf count times fan-in
  localparam int MAX_FAN_IN = 16;
  localparam int MAX_NODES  = 65536;
  localparam int LVL_N      = 16;     // at most this many tree levels above a node
  localparam int LVL_W      = 5;      // level counter, holds LVL_N
  localparam int LVL_IW     = 4;      // level index
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DAT_W  = 17;

  localparam logic REL_PARENT = 1'b0;
  localparam logic REL_CHILD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAN_IN     = 1'b0,
    REG_LEAF_COUNT = 1'b1
  } cfg_reg_e;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] dividend;
    logic [FAN_W-1:0]  divisor;
  } div_req_t;

  // answer of the shared divider
  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] quot;
    logic [FAN_W-1:0]  rem;
  } div_res_t;

endpackage

>>> sv/krtn_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, node number by fan-in
// depends on krtn_pkg
module krtn_div import krtn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int CNT_W = $clog2(NODE_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FAN_W-1:0]  rem_q, rem_d;
  logic [NODE_W-1:0] dq_q, dq_d;
  logic [FAN_W-1:0]  dsr_q, dsr_d;
  logic [FAN_W:0]    shifted;
  logic [FAN_W:0]    diff;
  logic              ge;

  assign shifted = {rem_q, dq_q[NODE_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dq_d   = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so five bits hold it
      rem_d = ge ? diff[FAN_W-1:0] : shifted[FAN_W-1:0];
      dq_d  = {dq_q[NODE_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NODE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dq_q;
  assign res_o.rem  = rem_q;

endmodule

>>> sv/kary_reduction_tree_neighbors.sv
`timescale 1ns / 1ps
// k-ary reduction tree neighbor query: parent first, then children, last flagged
// depends on krtn_pkg and krtn_div
//
//   channel   ports                                           handshake
//   --------  ----------------------------------------------  -------------------------
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i                write when cfg_we_i high
//   query     start_i, node_id_i                              taken when start_i && !busy_o
//   result    strobe_o, relation_o, neighbor_id_o, last_o     one-cycle strobe per item
//
// from the taking edge until busy_o drops, an item steps through T powers of the fan-in
// below the leaf count (one multiply each), D = L + 1 divisions by the fan-in for L
// dividing levels (issue, 16 divider steps, take the quotient), C direct children and
// one step per level for the power children
// busy_o is high from the cycle after the query is taken until the last result
// reset clears the sequencer and sets fan_in to 2 and leaf_count to 1
// results cannot be held off; each one is valid for exactly its strobe cycle
module kary_reduction_tree_neighbors import krtn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 start_i,
  input  logic [NODE_W-1:0]    node_id_i,
  output logic                 busy_o,
  output logic                 strobe_o,
  output logic                 relation_o,
  output logic [NODE_W-1:0]    neighbor_id_o,
  output logic                 last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,   // find the highest capped power of the fan-in
    S_DIVS,  // issue one division of the walk value by the fan-in
    S_DIVW,  // wait for the quotient, record one tree level
    S_PAR,   // parent item
    S_DIR,   // direct children n+1 .. n+f-1
    S_POW,   // children one power of the fan-in away
    S_FIN    // flush the held item with last set
  } state_e;

  // configuration registers
  logic [FAN_W-1:0]  fan_in_q, fan_in_d;
  logic [LEAF_W-1:0] leaf_count_q, leaf_count_d;

  // sequencer
  state_e            state_q, state_d;
  logic [NODE_W-1:0] n_q, n_d;          // queried node
  logic [FAN_W-1:0]  f_q, f_d;          // clamped fan-in
  logic [LEAF_W-1:0] lc_q, lc_d;        // clamped leaf count
  logic [PW_W-1:0]   pw_q, pw_d;        // running power, top search and child emit
  logic [PW_W-1:0]   top_q, top_d;      // highest power allowed as a step
  logic [NODE_W-1:0] v_q, v_d;          // node divided by the current power
  logic [PW_W-1:0]   kk_q, kk_d;        // power of the level being divided
  logic [PW_W-1:0]   best_q, best_d;    // largest capped power dividing the node
  logic [FAN_W-1:0]  r0_q, r0_d;        // node modulo fan-in
  logic              brk_q, brk_d;      // power children ran past the leaf count
  logic              pend_q, pend_d;    // previous level waits for its emit decision
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [LVL_N-1:0]  emit_q, emit_d;    // one bit per level: emit n + f^(level+1)
  logic [LVL_W-1:0]  idx_q, idx_d;

  // one item held back so that the last one can be flagged
  logic              hold_v_q, hold_v_d;
  logic              hold_rel_q, hold_rel_d;
  logic [NODE_W-1:0] hold_id_q, hold_id_d;

  // registered result ports
  logic              strobe_q, strobe_d;
  logic              rel_q, rel_d;
  logic [NODE_W-1:0] nid_q, nid_d;
  logic              last_q, last_d;

  // shared units
  div_req_t          div_req;
  div_res_t          div_res;
  logic [PW_W-1:0]   mul_a;
  logic [PW_W+FAN_W-1:0] mul_p;
  logic [PW_W-1:0]   mul_r;

  krtn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // one multiplier stepping powers of the fan-in: top search, level walk, power children
  assign mul_a = (state_q == S_DIVW) ? kk_q : pw_q;
  assign mul_p = mul_a * f_q;
  assign mul_r = mul_p[PW_W-1:0];

  assign div_req.start    = (state_q == S_DIVS);
  assign div_req.dividend = v_q;
  assign div_req.divisor  = f_q;

  always_comb begin
    logic              cand_v;
    logic              cand_rel;
    logic [NODE_W-1:0] cand_id;
    logic [FAN_W-1:0]  f_eff;
    logic [LEAF_W-1:0] lc_eff;
    logic [PW_W:0]     step_sum;
    logic [LEAF_W-1:0] dir_sum;
    logic              fits;

    fan_in_d     = fan_in_q;
    leaf_count_d = leaf_count_q;
    state_d      = state_q;
    n_d          = n_q;
    f_d          = f_q;
    lc_d         = lc_q;
    pw_d         = pw_q;
    top_d        = top_q;
    v_d          = v_q;
    kk_d         = kk_q;
    best_d       = best_q;
    r0_d         = r0_q;
    brk_d        = brk_q;
    pend_d       = pend_q;
    lvl_d        = lvl_q;
    emit_d       = emit_q;
    idx_d        = idx_q;
    hold_v_d     = hold_v_q;
    hold_rel_d   = hold_rel_q;
    hold_id_d    = hold_id_q;
    strobe_d     = 1'b0;
    rel_d        = rel_q;
    nid_d        = nid_q;
    last_d       = last_q;
    cand_v       = 1'b0;
    cand_rel     = REL_CHILD;
    cand_id      = '0;

    // out-of-range settings act as the nearest legal value
    if (fan_in_q < FAN_W'(2)) begin
      f_eff = FAN_W'(2);
    end else if (fan_in_q > FAN_W'(MAX_FAN_IN)) begin
      f_eff = FAN_W'(MAX_FAN_IN);
    end else begin
      f_eff = fan_in_q;
    end
    if (leaf_count_q == '0) begin
      lc_eff = LEAF_W'(1);
    end else if (leaf_count_q > LEAF_W'(MAX_NODES)) begin
      lc_eff = LEAF_W'(MAX_NODES);
    end else begin
      lc_eff = leaf_count_q;
    end

    step_sum = {{(PW_W - NODE_W + 1){1'b0}}, n_q} + {1'b0, kk_q};
    fits     = step_sum < (PW_W + 1)'(lc_q);
    dir_sum  = {1'b0, n_q} + LEAF_W'(idx_q);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FAN_IN:     fan_in_d     = cfg_wdata_i[FAN_W-1:0];
        REG_LEAF_COUNT: leaf_count_d = cfg_wdata_i[LEAF_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = node_id_i;
          f_d     = f_eff;
          lc_d    = lc_eff;
          pw_d    = PW_W'(1);
          top_d   = '0;
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        // top ends as the largest power below the leaf count, zero for one leaf
        if (pw_q < PW_W'(lc_q)) begin
          top_d = pw_q;
          pw_d  = mul_r;
        end else begin
          v_d     = n_q;
          kk_d    = PW_W'(f_q);
          best_d  = '0;
          brk_d   = 1'b0;
          pend_d  = 1'b0;
          lvl_d   = '0;
          emit_d  = '0;
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (div_res.done) begin
          if (lvl_q == '0) begin
            r0_d = div_res.rem;
          end
          // previous level's child is skipped when the next step up also lands on it
          if (pend_q) begin
            emit_d[LVL_IW'(lvl_q - LVL_W'(1))] =
              (div_res.rem != (f_q - FAN_W'(1))) || (kk_q > top_q);
          end
          pend_d = 1'b0;
          if ((div_res.rem == '0) && (kk_q <= top_q)) begin
            best_d  = kk_q;
            pend_d  = !brk_q && fits;
            brk_d   = brk_q || !fits;
            v_d     = div_res.quot;
            kk_d    = mul_r;
            lvl_d   = lvl_q + LVL_W'(1);
            state_d = S_DIVS;
          end else begin
            state_d = S_PAR;
          end
        end
      end
      S_PAR: begin
        cand_v   = 1'b1;
        cand_rel = REL_PARENT;
        if (n_q == '0) begin
          cand_id = '0;
        end else if (r0_q != '0) begin
          cand_id = n_q - NODE_W'(r0_q);
        end else if (best_q != '0) begin
          cand_id = n_q - best_q[NODE_W-1:0];
        end else begin
          cand_id = '0;
        end
        idx_d   = LVL_W'(1);
        state_d = S_DIR;
      end
      S_DIR: begin
        if ((r0_q == '0) && (idx_q < f_q) && (dir_sum < lc_q)) begin
          cand_v  = 1'b1;
          cand_id = dir_sum[NODE_W-1:0];
          idx_d   = idx_q + LVL_W'(1);
        end else begin
          idx_d   = '0;
          pw_d    = PW_W'(f_q);
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (idx_q < lvl_q) begin
          if (emit_q[idx_q[LVL_IW-1:0]]) begin
            cand_v  = 1'b1;
            cand_id = n_q + pw_q[NODE_W-1:0];
          end
          pw_d  = mul_r;
          idx_d = idx_q + LVL_W'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        strobe_d = hold_v_q;
        rel_d    = hold_rel_q;
        nid_d    = hold_id_q;
        last_d   = 1'b1;
        hold_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // a new item pushes the held one out, not last
    if (cand_v) begin
      if (hold_v_q) begin
        strobe_d = 1'b1;
        rel_d    = hold_rel_q;
        nid_d    = hold_id_q;
        last_d   = 1'b0;
      end
      hold_v_d   = 1'b1;
      hold_rel_d = cand_rel;
      hold_id_d  = cand_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_in_q     <= FAN_W'(2);
      leaf_count_q <= LEAF_W'(1);
      state_q      <= S_IDLE;
      brk_q        <= 1'b0;
      pend_q       <= 1'b0;
      hold_v_q     <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      fan_in_q     <= fan_in_d;
      leaf_count_q <= leaf_count_d;
      state_q      <= state_d;
      brk_q        <= brk_d;
      pend_q       <= pend_d;
      hold_v_q     <= hold_v_d;
      strobe_q     <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    f_q        <= f_d;
    lc_q       <= lc_d;
    pw_q       <= pw_d;
    top_q      <= top_d;
    v_q        <= v_d;
    kk_q       <= kk_d;
    best_q     <= best_d;
    r0_q       <= r0_d;
    lvl_q      <= lvl_d;
    emit_q     <= emit_d;
    idx_q      <= idx_d;
    hold_rel_q <= hold_rel_d;
    hold_id_q  <= hold_id_d;
    rel_q      <= rel_d;
    nid_q      <= nid_d;
    last_q     <= last_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign relation_o    = rel_q;
  assign neighbor_id_o = nid_q;
  assign last_o        = last_q;

endmodule

>>> sv/krtn_chk.sv
`timescale 1ns / 1ps
// port-level checks of the neighbor query block, bound to the top level
// depends on krtn_pkg and kary_reduction_tree_neighbors
module krtn_chk import krtn_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              strobe_o,
  input logic              relation_o,
  input logic [NODE_W-1:0] neighbor_id_o,
  input logic              last_o
);

  // a taken query makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("query taken but block not busy");

  // only the final item of a query appears after busy drops
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !busy_o) |-> last_o)
    else $error("non-final item while idle");

  // the final item marks the end of the query
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy_o)
    else $error("final item while still busy");

  // busy drops only together with the final item
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (strobe_o && last_o))
    else $error("busy dropped without final item");

  // every strobed item carries a known payload
  a_item_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !$isunknown({relation_o, neighbor_id_o, last_o}))
    else $error("item with unknown payload");

endmodule

bind kary_reduction_tree_neighbors krtn_chk u_krtn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .strobe_o      (strobe_o),
  .relation_o    (relation_o),
  .neighbor_id_o (neighbor_id_o),
  .last_o        (last_o)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for kary_reduction_tree_neighbors: parent/children queries
// depends on krtn_pkg and the kary_reduction_tree_neighbors rtl, nothing else
module tb;
  import krtn_pkg::*;

  // one result of a neighbor query
  typedef struct packed {
    logic              relation;
    logic [NODE_W-1:0] neighbor;
    logic              last;
  } neighbor_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 start_i;
  logic [NODE_W-1:0]    node_id_i;
  logic                 busy_o;
  logic                 strobe_o;
  logic                 relation_o;
  logic [NODE_W-1:0]    neighbor_id_o;
  logic                 last_o;

  // predictor copy of the two registers, reset values of the block
  logic [FAN_W-1:0]  fan_in_reg;
  logic [LEAF_W-1:0] leaf_count_reg;

  // results still owed by the block, oldest first
  neighbor_t   expected_neighbors[$];
  neighbor_t   want;
  int unsigned error_count;

  kary_reduction_tree_neighbors DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .node_id_i     (node_id_i),
    .busy_o        (busy_o),
    .strobe_o      (strobe_o),
    .relation_o    (relation_o),
    .neighbor_id_o (neighbor_id_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs; far above the slowest correct run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // fan-in and leaf count as the block actually uses them (clamped)
  function automatic longint unsigned eff_fan_in();
    longint unsigned f;
    f = fan_in_reg;
    if (f < 2) f = 2;
    if (f > MAX_FAN_IN) f = MAX_FAN_IN;
    return f;
  endfunction

  function automatic longint unsigned eff_leaf_count();
    longint unsigned lc;
    lc = leaf_count_reg;
    if (lc < 1) lc = 1;
    if (lc > MAX_NODES) lc = MAX_NODES;
    return lc;
  endfunction

  // works out parent and children of one node and queues them, last flagged
  function automatic void predict_neighbors(input logic [NODE_W-1:0] node);
    longint unsigned n, f, lc, top, par, k, i;
    bit              found;
    bit              stop;
    neighbor_t       answer[$];
    neighbor_t       r;
    n     = node;
    f     = eff_fan_in();
    lc    = eff_leaf_count();
    top   = 1;
    par   = 0;
    found = 1'b0;
    stop  = 1'b0;
    // highest power of the fan-in below the leaf count
    while (top < lc) top = top * f;
    top = top / f;

    // parent: next lower multiple, else step back by the largest dividing power
    if (n != 0) begin
      if (n % f != 0) begin
        par = n - (n % f);
      end else begin
        k = top;
        while (k > 1 && !found) begin
          if (n % k == 0) begin
            par   = n - k;
            found = 1'b1;
          end
          k = k / f;
        end
      end
    end
    r.relation = REL_PARENT;
    r.neighbor = par[NODE_W-1:0];
    r.last     = 1'b0;
    answer = {answer, r};

    // direct children sit right above a multiple of the fan-in
    r.relation = REL_CHILD;
    if (n % f == 0) begin
      for (i = 1; i < f; i++) begin
        if (n + i < lc) begin
          r.neighbor = n[NODE_W-1:0] + i[NODE_W-1:0];
          answer = {answer, r};
        end
      end
    end

    // children one power step away, only where this node is their parent
    for (k = f; k <= top && !stop; k = k * f) begin
      if (n % k != 0 || n + k >= lc) begin
        stop = 1'b1;
      end else if (k * f > top || ((n / k) + 1) % f != 0) begin
        r.neighbor = n[NODE_W-1:0] + k[NODE_W-1:0];
        answer = {answer, r};
      end
    end

    foreach (answer[j]) begin
      r      = answer[j];
      r.last = (j == answer.size() - 1);
      expected_neighbors = {expected_neighbors, r};
    end
  endfunction

  // result checker: every strobe must match the oldest outstanding result
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_neighbors.size() == 0) begin
        $display("%0t unexpected result: relation %0d neighbor %0d last %0d",
                 $time, relation_o, neighbor_id_o, last_o);
        error_count++;
      end else begin
        want = expected_neighbors.pop_front();
        if (relation_o !== want.relation) begin
          $display("%0t relation mismatch: expected %0d actual %0d",
                   $time, want.relation, relation_o);
          error_count++;
        end
        if (neighbor_id_o !== want.neighbor) begin
          $display("%0t neighbor_id mismatch: expected %0d actual %0d",
                   $time, want.neighbor, neighbor_id_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t last mismatch: expected %0d actual %0d",
                   $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // offers one item and returns at the edge that takes it;
  // start stays high so a following item goes out without a bubble
  task automatic send_node(input logic [NODE_W-1:0] node);
    @(negedge clk_i);
    start_i   <= 1'b1;
    node_id_i <= node;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_neighbors(node);
  endtask

  // sender idles for some cycles, with junk on the node bus
  task automatic idle_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i   <= 1'b0;
      node_id_i <= NODE_W'($urandom);
    end
  endtask

  // hold off until every owed result has come and the block is idle
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_neighbors.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes both registers on back-to-back cycles, only while idle
  task automatic configure(input logic [CFG_DAT_W-1:0] fan_data,
                           input logic [CFG_DAT_W-1:0] leaf_data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FAN_IN;
    cfg_wdata_i <= fan_data;
    @(posedge clk_i);
    fan_in_reg = fan_data[FAN_W-1:0];
    @(negedge clk_i);
    cfg_idx_i   <= REG_LEAF_COUNT;
    cfg_wdata_i <= leaf_data;
    @(posedge clk_i);
    leaf_count_reg = leaf_data[LEAF_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
  endtask

  // picks a node that tends to sit high in the tree so the deep paths get hit
  function automatic logic [NODE_W-1:0] pick_node();
    longint unsigned f, lc, p, m;
    int unsigned     sel;
    f   = eff_fan_in();
    lc  = eff_leaf_count();
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      p = 1;
      while (p * f < lc && $urandom_range(0, 3) != 0) p = p * f;
      m = $urandom_range(0, int'(lc - 1));
      m = m - (m % p);
    end else if (sel < 85) begin
      m = $urandom_range(0, int'(lc - 1));
    end else if (sel < 95) begin
      // anything the port allows, out of range included
      m = $urandom_range(0, 65535);
    end else begin
      m = sel[0] ? lc - 1 : 0;
    end
    return m[NODE_W-1:0];
  endfunction

  // reset values: binary tree of a single leaf
  task automatic test_reset_state();
    send_node(16'd0);
    send_node(16'd1);
    send_node(16'hFFFF);
  endtask

  // widest fan-in on the largest tree, node 0 gives the longest answer
  task automatic test_widest_tree();
    configure(CFG_DAT_W'(16), CFG_DAT_W'(65536));
    send_node(16'd0);
    send_node(16'd4096);
    send_node(16'd65535);
    send_node(16'd61440);
    send_node(16'd256);
  endtask

  // deepest tree: fan-in 2 over all ranks
  task automatic test_binary_tree();
    configure(CFG_DAT_W'(2), CFG_DAT_W'(65536));
    send_node(16'd0);
    send_node(16'd32768);
    send_node(16'd1);
    send_node(16'd65534);
  endtask

  // tree top below the fan-in: multiples find no dividing power, parent 0;
  // nodes past the leaf count still answered with children filtered
  task automatic test_no_dividing_power();
    configure(CFG_DAT_W'(16), CFG_DAT_W'(10));
    send_node(16'd32);
    send_node(16'd16);
    send_node(16'd9);
    send_node(16'd100);
  endtask

  // register values outside the legal range get clamped by the block
  task automatic test_clamped_config();
    configure(CFG_DAT_W'(0), CFG_DAT_W'(0));
    send_node(16'd2);
    send_node(16'd0);
    configure(CFG_DAT_W'(31), CFG_DAT_W'(131071));
    send_node(16'd0);
    send_node(16'd4352);
    configure(CFG_DAT_W'(1), CFG_DAT_W'(65537));
    send_node(16'd6);
    send_node(16'd8);
    configure(CFG_DAT_W'(17), CFG_DAT_W'(100));
    send_node(16'd16);
  endtask

  // random settings per phase, random items in bursts with random gaps
  task automatic test_random_queries();
    int unsigned      burst_left;
    int unsigned      fan_val;
    int unsigned      leaf_val;
    logic [CFG_DAT_W-1:0] fan_data;
    burst_left = 0;
    for (int phase = 0; phase < 9; phase++) begin
      if ($urandom_range(0, 7) == 0) fan_val = $urandom_range(0, 31);
      else fan_val = $urandom_range(2, 16);
      // upper data bits are junk for the fan-in register
      fan_data = {12'($urandom), 5'(fan_val)};
      case ($urandom_range(0, 9))
        0, 1, 2: leaf_val = $urandom_range(1, 64);
        3, 4, 5: leaf_val = $urandom_range(65, 4096);
        6, 7:    leaf_val = $urandom_range(4097, 65536);
        8:       leaf_val = 65536;
        default: leaf_val = $urandom_range(0, 1) ? 0 : $urandom_range(65537, 131071);
      endcase
      configure(fan_data, CFG_DAT_W'(leaf_val));
      for (int n = 0; n < 23; n++) begin
        // first phase runs with no idling at all
        if (phase != 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(20, 400));
            else idle_gap($urandom_range(1, 6));
          end
          burst_left--;
          // now and then let the block drain completely before the next item
          if ($urandom_range(0, 29) == 0) wait_idle();
        end
        send_node(pick_node());
      end
    end
  endtask

  // drain, then watch a while longer for stray results
  task automatic finish_run();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    start_i <= 1'b0;
    @(posedge clk_i);
    while ((expected_neighbors.size() != 0 || busy_o) && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (expected_neighbors.size() != 0) begin
      $display("%0t %0d expected results never arrived",
               $time, expected_neighbors.size());
      error_count++;
    end
  endtask

  initial begin
    error_count    = 0;
    fan_in_reg     = FAN_W'(2);
    leaf_count_reg = LEAF_W'(1);
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_FAN_IN;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    node_id_i   <= '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_widest_tree();
    test_binary_tree();
    test_no_dividing_power();
    test_clamped_config();
    test_random_queries();
    finish_run();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/krtn_pkg.sv
sv/krtn_div.sv
sv/kary_reduction_tree_neighbors.sv
sv/krtn_chk.sv
tb/tb.sv
